// File: hw/rtl/led_blink_code_indicator_macros.svh
// Assertion macros for the LED blink code indicator.
`ifndef LED_BLINK_CODE_INDICATOR_MACROS_SVH
`define LED_BLINK_CODE_INDICATOR_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge out of reset.
`define LBC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle brings another in the next cycle.
`define LBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define LBC_ASSERT_ALWAYS(label, cond, msg)
`define LBC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/ledbc_pkg.sv
// Types, constants and lookup tables shared by the LED blink code indicator.
package ledbc_pkg;

  localparam int unsigned GROUP_FLASHES = 5;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DUR_W    = 24;
  localparam int unsigned STAGE_W  = 3;
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [STAGE_W-1:0] FAIL_STAGE = 3'd7;

  localparam logic [DUR_W-1:0] FLASH_ON_RST  = 24'd120000;
  localparam logic [DUR_W-1:0] FLASH_OFF_RST = 24'd120000;
  localparam logic [DUR_W-1:0] GROUP_GAP_RST = 24'd800000;
  localparam logic [DUR_W-1:0] MID_GAP_RST   = 24'd1500000;
  localparam logic [DUR_W-1:0] CYCLE_GAP_RST = 24'd2500000;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_CYCLE_GAP    = 4'd1,
    PH_STAGE_ON     = 4'd2,
    PH_STAGE_OFF    = 4'd3,
    PH_STAGE_GROUP  = 4'd4,
    PH_MID_GAP      = 4'd5,
    PH_STATUS_ON    = 4'd6,
    PH_STATUS_OFF   = 4'd7,
    PH_STATUS_GROUP = 4'd8
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLASH_ON  = 3'd0,
    CFG_FLASH_OFF = 3'd1,
    CFG_GROUP_GAP = 3'd2,
    CFG_MID_GAP   = 3'd3,
    CFG_CYCLE_GAP = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DUR_W-1:0] flash_on_time;
    logic [DUR_W-1:0] flash_off_time;
    logic [DUR_W-1:0] group_gap_time;
    logic [DUR_W-1:0] mid_gap_time;
    logic [DUR_W-1:0] cycle_gap_time;
  } ledbc_cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [TIME_W-1:0]   phase_start;
    logic [STAGE_W-1:0]  cycle_stage;
    logic [STATUS_W-1:0] cycle_status;
    logic [STATUS_W-1:0] flashes_remaining;
    logic                led_level;
  } ledbc_state_t;

  // Bit i is set when i flashes done closes a group.
  function automatic logic [2**STATUS_W-1:0] group_end_table();
    logic [2**STATUS_W-1:0] tbl;
    int unsigned            cnt;
    tbl = '0;
    cnt = 0;
    for (int i = 0; i < 2**STATUS_W; i++) begin
      tbl[i] = (cnt == 0);
      cnt = (cnt == GROUP_FLASHES - 1) ? 0 : cnt + 1;
    end
    return tbl;
  endfunction

  localparam logic [2**STATUS_W-1:0] GROUP_END_TBL = group_end_table();

endpackage

// File: hw/rtl/ledbc_step.sv
// Next-state and LED logic for one tick of the blink code sequencer.
module ledbc_step (
  input  ledbc_pkg::ledbc_cfg_t                 cfg,
  input  ledbc_pkg::ledbc_state_t               cur,
  input  logic [ledbc_pkg::TIME_W-1:0]          now_us,
  input  logic [ledbc_pkg::STAGE_W-1:0]         stage,
  input  logic [ledbc_pkg::STATUS_W-1:0]        status_code,
  output ledbc_pkg::ledbc_state_t               nxt,
  output logic                                  led_changed
);
  import ledbc_pkg::*;

  logic [TIME_W-1:0]   elapsed;
  logic [DUR_W-1:0]    limit;
  logic                timed_out;
  logic [STATUS_W-1:0] total;
  logic [STATUS_W-1:0] done;
  logic                group_end;
  logic [STATUS_W-1:0] remaining_dec;

  assign elapsed = now_us - cur.phase_start;

  // One shared compare: pick the wait that belongs to the current phase.
  always_comb begin
    case (cur.phase)
      PH_CYCLE_GAP:                     limit = cfg.cycle_gap_time;
      PH_STAGE_ON, PH_STATUS_ON:        limit = cfg.flash_on_time;
      PH_STAGE_OFF, PH_STATUS_OFF:      limit = cfg.flash_off_time;
      PH_STAGE_GROUP, PH_STATUS_GROUP:  limit = cfg.group_gap_time;
      PH_MID_GAP:                       limit = cfg.mid_gap_time;
      default:                          limit = '0;
    endcase
  end

  assign timed_out = (elapsed >= {{(TIME_W-DUR_W){1'b0}}, limit});

  assign total = (cur.phase == PH_STATUS_OFF) ? cur.cycle_status
                                               : {{(STATUS_W-STAGE_W){1'b0}}, cur.cycle_stage};
  assign done      = total - cur.flashes_remaining;
  assign group_end = GROUP_END_TBL[done];

  // Hold the counter at zero instead of wrapping.
  assign remaining_dec = (cur.flashes_remaining != '0) ? cur.flashes_remaining - 1'b1
                                                       : cur.flashes_remaining;

  always_comb begin
    nxt = cur;
    case (cur.phase)
      PH_CYCLE_GAP: begin
        if (timed_out) begin
          nxt.cycle_stage  = stage;
          nxt.cycle_status = status_code;
          nxt.phase_start  = now_us;
          if (stage == '0) begin
            nxt.led_level = 1'b0;
            nxt.phase     = PH_IDLE;
          end else begin
            nxt.flashes_remaining = {{(STATUS_W-STAGE_W){1'b0}}, stage};
            nxt.led_level         = 1'b1;
            nxt.phase             = PH_STAGE_ON;
          end
        end
      end
      PH_STAGE_ON, PH_STATUS_ON: begin
        if (timed_out) begin
          nxt.led_level         = 1'b0;
          nxt.flashes_remaining = remaining_dec;
          nxt.phase_start       = now_us;
          nxt.phase = (cur.phase == PH_STAGE_ON) ? PH_STAGE_OFF : PH_STATUS_OFF;
        end
      end
      PH_STAGE_OFF: begin
        if (timed_out) begin
          nxt.phase_start = now_us;
          if (cur.flashes_remaining == '0) begin
            if (cur.cycle_stage == FAIL_STAGE && cur.cycle_status != '0) begin
              nxt.phase = PH_MID_GAP;
            end else begin
              nxt.phase = PH_CYCLE_GAP;
            end
          end else if (group_end) begin
            nxt.phase = PH_STAGE_GROUP;
          end else begin
            nxt.led_level = 1'b1;
            nxt.phase     = PH_STAGE_ON;
          end
        end
      end
      PH_STATUS_OFF: begin
        if (timed_out) begin
          nxt.phase_start = now_us;
          if (cur.flashes_remaining == '0) begin
            nxt.phase = PH_CYCLE_GAP;
          end else if (group_end) begin
            nxt.phase = PH_STATUS_GROUP;
          end else begin
            nxt.led_level = 1'b1;
            nxt.phase     = PH_STATUS_ON;
          end
        end
      end
      PH_STAGE_GROUP, PH_STATUS_GROUP: begin
        if (timed_out) begin
          nxt.led_level   = 1'b1;
          nxt.phase_start = now_us;
          nxt.phase = (cur.phase == PH_STAGE_GROUP) ? PH_STAGE_ON : PH_STATUS_ON;
        end
      end
      PH_MID_GAP: begin
        if (timed_out) begin
          nxt.flashes_remaining = cur.cycle_status;
          nxt.led_level         = 1'b1;
          nxt.phase_start       = now_us;
          nxt.phase             = PH_STATUS_ON;
        end
      end
      default: begin
        // Idle, and any unused phase code.
        nxt.phase = PH_IDLE;
        if (stage != '0) begin
          nxt.cycle_stage  = stage;
          nxt.cycle_status = status_code;
          nxt.led_level    = 1'b0;
          nxt.phase_start  = now_us;
          nxt.phase        = PH_CYCLE_GAP;
        end
      end
    endcase
  end

  assign led_changed = (nxt.led_level != cur.led_level);

endmodule

// File: hw/rtl/led_blink_code_indicator.sv
// LED blink code indicator: one tick item in, one LED level item out. Each
// tick is captured in an input register, run through the sequencer's
// next-state logic in a single pass and stored in the result register, so
// the block takes one tick every clock cycle unless the result side stalls;
// the throughput is set by the sequencer's phase update, and the input side
// keeps accepting while a result waits as long as the result register is
// freed in the same cycle. Durations are 24-bit microsecond counts written
// through the cfg port (index 0 on time, 1 off time, 2 group gap, 3 mid gap,
// 4 gap between cycles; other indexes are ignored); a write applies to the very next
// item the sequencer handles, so write only while no item is in flight.
// Elapsed time wraps modulo 2^32. There is no clearing pass after reset.
`include "led_blink_code_indicator_macros.svh"

module led_blink_code_indicator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ledbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ledbc_pkg::DUR_W-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ledbc_pkg::TIME_W-1:0]         in_now_us,
  input  logic [ledbc_pkg::STAGE_W-1:0]        in_stage,
  input  logic [ledbc_pkg::STATUS_W-1:0]       in_status_code,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_led_on,
  output logic                                 out_led_changed
);
  import ledbc_pkg::*;

  ledbc_cfg_t          cfg_r;
  ledbc_state_t        st_r;
  ledbc_state_t        st_nxt;
  logic                step_changed;

  logic                s1_valid_r;
  logic [TIME_W-1:0]   s1_now_r;
  logic [STAGE_W-1:0]  s1_stage_r;
  logic [STATUS_W-1:0] s1_status_r;

  logic                out_valid_r;
  logic                out_led_on_r;
  logic                out_led_changed_r;

  logic                out_free;
  logic                s1_adv;
  logic                in_take;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flash_on_time  <= FLASH_ON_RST;
      cfg_r.flash_off_time <= FLASH_OFF_RST;
      cfg_r.group_gap_time <= GROUP_GAP_RST;
      cfg_r.mid_gap_time   <= MID_GAP_RST;
      cfg_r.cycle_gap_time <= CYCLE_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FLASH_ON:  cfg_r.flash_on_time  <= cfg_wdata;
        CFG_FLASH_OFF: cfg_r.flash_off_time <= cfg_wdata;
        CFG_GROUP_GAP: cfg_r.group_gap_time <= cfg_wdata;
        CFG_MID_GAP:   cfg_r.mid_gap_time   <= cfg_wdata;
        CFG_CYCLE_GAP: cfg_r.cycle_gap_time <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: hold the tick while the result side is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r    <= in_now_us;
      s1_stage_r  <= in_stage;
      s1_status_r <= in_status_code;
    end
  end

  ledbc_step u_step (
    .cfg         (cfg_r),
    .cur         (st_r),
    .now_us      (s1_now_r),
    .stage       (s1_stage_r),
    .status_code (s1_status_r),
    .nxt         (st_nxt),
    .led_changed (step_changed)
  );

  // Sequencer state advances once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase             <= PH_IDLE;
      st_r.phase_start       <= '0;
      st_r.cycle_stage       <= '0;
      st_r.cycle_status      <= '0;
      st_r.flashes_remaining <= '0;
      st_r.led_level         <= 1'b0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_led_on_r      <= st_nxt.led_level;
      out_led_changed_r <= step_changed;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_on      = out_led_on_r;
  assign out_led_changed = out_led_changed_r;

  `LBC_ASSERT_ALWAYS(a_led_only_in_on_phase, !st_r.led_level || st_r.phase == PH_STAGE_ON || st_r.phase == PH_STATUS_ON, "LED lit outside a flash phase")
  `LBC_ASSERT_NEXT(a_result_matches_state, s1_adv, out_valid_r && out_led_on_r == st_r.led_level, "result item does not match LED state")
  `LBC_ASSERT_ALWAYS(a_stall_only_when_full, in_ready || (s1_valid_r && out_valid_r), "input stalled with room in the pipeline")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LED blink code indicator.
module tb_top;
  import ledbc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int NUM_REGS = int'(CFG_CYCLE_GAP) + 1;
  localparam logic [STAGE_W-1:0] STAGE_IDLE = '0;
  localparam logic [STATUS_W-1:0] STATUS_NONE = '0;

  typedef struct packed {
    logic led_on;
    logic led_changed;
  } led_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [TIME_W-1:0]   in_now_us;
  logic [STAGE_W-1:0]  in_stage;
  logic [STATUS_W-1:0] in_status_code;
  logic                out_valid;
  logic                out_ready;
  logic                out_led_on;
  logic                out_led_changed;

  // Sequencer state and timing as the block should hold them
  phase_t              seq_phase;
  logic [TIME_W-1:0]   seq_start;
  logic [STAGE_W-1:0]  seq_stage;
  logic [STATUS_W-1:0] seq_status;
  logic [STATUS_W-1:0] seq_left;
  logic                seq_led;
  logic [DUR_W-1:0]    dur_us [NUM_REGS];

  led_result_t         led_expect_q [$];
  led_result_t         want_res;
  int unsigned         fail_count = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         src_burst = 0;
  int unsigned         sink_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  led_blink_code_indicator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_now_us       (in_now_us),
    .in_stage        (in_stage),
    .in_status_code  (in_status_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_led_on      (out_led_on),
    .out_led_changed (out_led_changed)
  );

  function automatic int unsigned pick_stall();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (src_burst != 0) begin
      src_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) src_burst = $urandom_range(20, 80);
    if (r < 60) return 0;
    return pick_stall();
  endfunction

  function automatic logic [DUR_W-1:0] pick_dur();
    case ($urandom_range(0, 3))
      0: return DUR_W'(1);
      1: return DUR_W'($urandom_range(1, 64));
      2: return DUR_W'($urandom);
      default: return '1;
    endcase
  endfunction

  // Duration that ends the given phase.
  function automatic logic [DUR_W-1:0] phase_wait(phase_t ph);
    case (ph)
      PH_CYCLE_GAP: return dur_us[CFG_CYCLE_GAP];
      PH_STAGE_ON, PH_STATUS_ON: return dur_us[CFG_FLASH_ON];
      PH_STAGE_OFF, PH_STATUS_OFF: return dur_us[CFG_FLASH_OFF];
      PH_STAGE_GROUP, PH_STATUS_GROUP: return dur_us[CFG_GROUP_GAP];
      PH_MID_GAP: return dur_us[CFG_MID_GAP];
      default: return '0;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] boundary_time(int jitter);
    return seq_start + TIME_W'(phase_wait(seq_phase)) + TIME_W'(jitter);
  endfunction

  task automatic move_to(input phase_t nxt, input logic [TIME_W-1:0] now);
    seq_phase = nxt;
    seq_start = now;
  endtask

  // Close one flash: LED off, count down but hold at zero.
  task automatic end_flash(input phase_t nxt, input logic [TIME_W-1:0] now);
    seq_led = 1'b0;
    if (seq_left != '0) seq_left = seq_left - 1'b1;
    move_to(nxt, now);
  endtask

  // After an off time: a completed group of flashes takes the group gap.
  task automatic next_flash(input logic [STATUS_W-1:0] total, input phase_t grp_ph,
                            input phase_t on_ph, input logic [TIME_W-1:0] now);
    logic [STATUS_W-1:0] done;
    done = total - seq_left;
    if (done % GROUP_FLASHES == 0) begin
      move_to(grp_ph, now);
    end else begin
      seq_led = 1'b1;
      move_to(on_ph, now);
    end
  endtask

  task automatic predict_blink(input logic [TIME_W-1:0] now, input logic [STAGE_W-1:0] stg,
                               input logic [STATUS_W-1:0] sts, output led_result_t res);
    logic              led_was;
    logic [TIME_W-1:0] elapsed;
    logic              expired;
    led_was = seq_led;
    elapsed = now - seq_start;
    expired = elapsed >= TIME_W'(phase_wait(seq_phase));
    case (seq_phase)
      PH_CYCLE_GAP: if (expired) begin
        seq_stage = stg;
        seq_status = sts;
        if (stg == STAGE_IDLE) begin
          seq_led = 1'b0;
          move_to(PH_IDLE, now);
        end else begin
          seq_left = STATUS_W'(stg);
          seq_led = 1'b1;
          move_to(PH_STAGE_ON, now);
        end
      end
      PH_STAGE_ON: if (expired) end_flash(PH_STAGE_OFF, now);
      PH_STAGE_OFF: if (expired) begin
        if (seq_left != '0)
          next_flash(STATUS_W'(seq_stage), PH_STAGE_GROUP, PH_STAGE_ON, now);
        else if (seq_stage == FAIL_STAGE && seq_status != STATUS_NONE)
          move_to(PH_MID_GAP, now);
        else
          move_to(PH_CYCLE_GAP, now);
      end
      PH_STAGE_GROUP: if (expired) begin
        seq_led = 1'b1;
        move_to(PH_STAGE_ON, now);
      end
      PH_MID_GAP: if (expired) begin
        seq_left = seq_status;
        seq_led = 1'b1;
        move_to(PH_STATUS_ON, now);
      end
      PH_STATUS_ON: if (expired) end_flash(PH_STATUS_OFF, now);
      PH_STATUS_OFF: if (expired) begin
        if (seq_left != '0)
          next_flash(seq_status, PH_STATUS_GROUP, PH_STATUS_ON, now);
        else
          move_to(PH_CYCLE_GAP, now);
      end
      PH_STATUS_GROUP: if (expired) begin
        seq_led = 1'b1;
        move_to(PH_STATUS_ON, now);
      end
      default: begin
        seq_phase = PH_IDLE;
        if (stg != STAGE_IDLE) begin
          seq_stage = stg;
          seq_status = sts;
          seq_led = 1'b0;
          move_to(PH_CYCLE_GAP, now);
        end
      end
    endcase
    res.led_on = seq_led;
    res.led_changed = (seq_led != led_was);
  endtask

  task automatic send_tick(input logic [TIME_W-1:0] now, input logic [STAGE_W-1:0] stg,
                           input logic [STATUS_W-1:0] sts);
    int unsigned gap;
    led_result_t res;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_now_us <= now;
    in_stage <= stg;
    in_status_code <= sts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_blink(now, stg, sts, res);
    led_expect_q.push_back(res);
  endtask

  task automatic random_tick();
    logic [TIME_W-1:0]   now;
    logic [STAGE_W-1:0]  stg;
    logic [STATUS_W-1:0] sts;
    int unsigned         r;
    r = $urandom_range(0, 99);
    if (r < 5)
      now = $urandom;
    else if (r < 20)
      now = seq_start + $urandom_range(0, phase_wait(seq_phase));
    else
      now = boundary_time(int'($urandom_range(0, 4)) - 2);
    r = $urandom_range(0, 99);
    stg = (r < 10) ? STAGE_IDLE : (r < 40) ? FAIL_STAGE : STAGE_W'($urandom_range(1, 6));
    r = $urandom_range(0, 99);
    sts = (r < 15) ? STATUS_NONE :
          (r < 95) ? STATUS_W'($urandom_range(1, 12)) : STATUS_W'($urandom_range(13, 255));
    send_tick(now, stg, sts);
  endtask

  // Step through one whole pattern cycle, each tick landing on a phase boundary.
  task automatic walk_cycle(input logic [STAGE_W-1:0] stg, input logic [STATUS_W-1:0] sts);
    if (seq_phase == PH_IDLE) send_tick(boundary_time(0), stg, sts);
    do
      send_tick(boundary_time(0), stg, sts);
    while (seq_phase != PH_CYCLE_GAP);
  endtask

  // Bring the sequencer back to idle and let every result drain.
  task automatic settle_idle();
    while (seq_phase != PH_IDLE)
      send_tick(boundary_time(0), STAGE_IDLE, STATUS_W'($urandom));
    in_valid <= 1'b0;
    while (led_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_timing(input logic [DUR_W-1:0] on_us, off_us, grp_us, mid_us, cyc_us);
    logic [DUR_W-1:0] vals [NUM_REGS];
    vals = '{on_us, off_us, grp_us, mid_us, cyc_us};
    settle_idle();
    // Unmapped indexes get junk data; it must not land anywhere.
    for (int i = 0; i < 2**CFG_IDX_W; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= (i < NUM_REGS) ? vals[i] : DUR_W'($urandom);
      @(posedge clk);
      if (i < NUM_REGS) dur_us[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_timing();
    send_tick('1, STAGE_IDLE, '1);
    send_tick(32'hFFFF_FFF0, 3'd1, STATUS_NONE);
    send_tick(boundary_time(-1), 3'd1, STATUS_NONE);
    send_tick(boundary_time(0), 3'd1, STATUS_NONE);
    send_tick(boundary_time(-1), 3'd1, STATUS_NONE);
    send_tick(boundary_time(0), 3'd1, STATUS_NONE);
    send_tick(boundary_time(-1), 3'd1, STATUS_NONE);
    send_tick(boundary_time(0), 3'd1, STATUS_NONE);
    walk_cycle(FAIL_STAGE, 8'd1);
    // zero stage at cycle start drops back to idle
    send_tick(boundary_time(0), STAGE_IDLE, 8'd1);
    repeat (120) random_tick();
  endtask

  task automatic test_longest_timing();
    load_timing('1, '1, '1, '1, '1);
    repeat (100) random_tick();
  endtask

  task automatic test_short_timing();
    repeat (2) begin
      load_timing(DUR_W'($urandom_range(1, 8)), DUR_W'($urandom_range(1, 8)),
                  DUR_W'($urandom_range(1, 8)), DUR_W'($urandom_range(1, 8)),
                  DUR_W'($urandom_range(1, 8)));
      repeat (80) random_tick();
    end
  endtask

  task automatic test_full_status_walk();
    load_timing(DUR_W'(1), DUR_W'(1), DUR_W'(1), DUR_W'(1), DUR_W'(1));
    walk_cycle(FAIL_STAGE, '1);
    repeat (50) random_tick();
  endtask

  task automatic test_zero_timing();
    load_timing('0, '0, '0, '0, '0);
    walk_cycle(3'd6, STATUS_NONE);
    repeat (100) random_tick();
  endtask

  task automatic test_mixed_timing();
    repeat (2) begin
      load_timing(pick_dur(), pick_dur(), pick_dur(), pick_dur(), pick_dur());
      repeat (50) random_tick();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_now_us <= '0;
    in_stage <= '0;
    in_status_code <= '0;
    out_ready <= 1'b0;
    seq_phase = PH_IDLE;
    seq_start = '0;
    seq_stage = '0;
    seq_status = '0;
    seq_left = '0;
    seq_led = 1'b0;
    dur_us[CFG_FLASH_ON] = FLASH_ON_RST;
    dur_us[CFG_FLASH_OFF] = FLASH_OFF_RST;
    dur_us[CFG_GROUP_GAP] = GROUP_GAP_RST;
    dur_us[CFG_MID_GAP] = MID_GAP_RST;
    dur_us[CFG_CYCLE_GAP] = CYCLE_GAP_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_timing();
    test_longest_timing();
    test_short_timing();
    test_full_status_walk();
    test_zero_timing();
    test_mixed_timing();

    in_valid <= 1'b0;
    while (led_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: ready runs of random length broken by stalls.
  always @(posedge clk) begin
    if (sink_left != 0) begin
      sink_left <= sink_left - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      sink_left <= pick_stall() - 1;
    end else begin
      out_ready <= 1'b1;
      sink_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
                                                 $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (led_expect_q.size() == 0) begin
        $error("unexpected item: led_on %0b led_changed %0b", out_led_on, out_led_changed);
        fail_count++;
      end else begin
        want_res = led_expect_q.pop_front();
        if (out_led_on !== want_res.led_on) begin
          $error("led_on: expected %0b, actual %0b", want_res.led_on, out_led_on);
          fail_count++;
        end
        if (out_led_changed !== want_res.led_changed) begin
          $error("led_changed: expected %0b, actual %0b", want_res.led_changed,
                 out_led_changed);
          fail_count++;
        end
      end
    end
  end

  // End the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
